### rtl/tcg_pkg.sv
package tcg_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int PHASE_BITS_DEF  = 48;

   localparam int MODE_BITS      = 2;
   localparam int STEP_BITS      = 48;
   localparam int COUNT_BITS     = 24;
   localparam int CSR_INDEX_BITS = 8;
   localparam int PHASE_MAX_BITS = 64;
   localparam int REQ_DATA_BITS  = 8;

   // Half of pi in Q30, slightly below the exact value.
   localparam longint unsigned PIH_Q30 = 64'd1686629711;
   localparam longint          ONE_Q30 = 64'sd1073741824;
   localparam longint          HALF_Q30 = 64'sd536870912;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_TONE    = 2'd0,
      MODE_CHIRP   = 2'd1,
      MODE_SILENCE = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE  = 8'd0,
      CSR_START = 8'd1,
      CSR_CHIRP = 8'd2,
      CSR_COUNT = 8'd3
   } csr_index_type;

   // Largest power of two not above depth, as its exponent (at most 14).
   function automatic int floor_log2(input int depth);
      int n;
      n = 0;
      while (n < 14 && (1 << (n + 1)) <= depth) begin
         n = n + 1;
      end
      return n;
   endfunction

   // Quarter-wave entry: sine by its Taylor series to the eleventh power in Q30,
   // scaled to the full positive amplitude and rounded.
   function automatic int sine_entry(input int unsigned i, input int log2d,
                                     input int sbits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint          sum;
      longint          amp;
      x   = (PIH_Q30 * longint'(i)) >> log2d;
      x2  = (x * x) >> 30;
      mag = x;
      sum = longint'(x);
      mag = ((mag * x2) >> 30) / 6;
      sum = sum - longint'(mag);
      mag = ((mag * x2) >> 30) / 20;
      sum = sum + longint'(mag);
      mag = ((mag * x2) >> 30) / 42;
      sum = sum - longint'(mag);
      mag = ((mag * x2) >> 30) / 72;
      sum = sum + longint'(mag);
      mag = ((mag * x2) >> 30) / 110;
      sum = sum - longint'(mag);
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      amp = (longint'(1) << (sbits - 1)) - 1;
      sum = (sum * amp + HALF_Q30) >>> 30;
      if (sum > amp) sum = amp;
      return int'(sum);
   endfunction

endpackage

### rtl/tone_chirp_generator_unit.sv
// Sine oscillator with tone, linear chirp and silence modes.
// The csr_ channel writes mode, start step, chirp step and sample count; it is
// always ready and should only be used while no run is in progress.
// Each word on the req_ channel is one tick: restart (req_tdata bit 0) set
// begins a new run at sample zero and emits that sample, clear emits the next
// sample of the current run. A tick while idle, or a restart with a sample count
// of zero, gives no word on the rsp_ channel.
// Each rsp_ word carries one signed sample in rsp_tdata, with rsp_tlast marking
// the final sample of the run.
// An accepted req_ word passes the synchronous read of the quarter-wave table and
// then the output register on its way to the rsp_ channel.
// Throughput is one word per cycle while the receiver takes every word, bounded by
// the phase accumulator update and the single table read port.
// After reset the block is idle, with its settings, oscillator state and valid flags cleared.
// When the receiver stalls, the table read and output registers hold their words
// and req_tready falls only once both of them are full.
module tone_chirp_generator_unit
   import tcg_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [REQ_DATA_BITS-1:0]             req_tdata,  // [0] restart
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,  // sample
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]            csr_index,
   input  logic [STEP_BITS-1:0]                 csr_wdata
);

   localparam int TAB_LOG2      = floor_log2(TABLE_DEPTH);
   localparam int DEPTH         = 1 << TAB_LOG2;
   localparam int ADDR_BITS     = TAB_LOG2 + 1;
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   typedef logic signed [SAMPLE_BITS-1:0] rom_type [0:DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i <= DEPTH; i++) begin
         r[i] = SAMPLE_BITS'(sine_entry(i, TAB_LOG2, SAMPLE_BITS));
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Configuration registers
   logic [MODE_BITS-1:0]  mode_ff;
   logic [STEP_BITS-1:0]  start_ff;
   logic [STEP_BITS-1:0]  chirp_ff;
   logic [COUNT_BITS-1:0] count_ff;

   // Oscillator state
   logic [PHASE_BITS-1:0] acc_ff, acc_in;
   logic [PHASE_BITS-1:0] inc_ff, inc_in;
   logic [COUNT_BITS-1:0] index_ff, index_in;
   logic                  running_ff, running_in;

   // Table read stage
   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rom_q_ff;
   logic                          s1_neg_ff, s1_mute_ff, s1_last_ff;

   // Output register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                     rsp_last_ff;

   logic                  adv2, adv1, accept, restart, is_chirp;
   logic [PHASE_BITS-1:0] start_ext, chirp_ext, chirp_two;
   logic [PHASE_BITS-1:0] cur_acc, cur_inc;
   logic [COUNT_BITS-1:0] cur_index;
   logic                  cur_run, emit, last;
   logic [1:0]            quad;
   logic [TAB_LOG2-1:0]   tab_idx;
   logic [ADDR_BITS-1:0]  rom_addr;
   logic signed [SAMPLE_BITS-1:0] sample_val;

   assign adv2       = !rsp_valid_ff || rsp_tready;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_tready = adv1;
   assign accept     = req_tvalid && adv1;
   assign restart    = req_tdata[0];
   assign is_chirp   = (mode_ff == MODE_CHIRP);
   assign csr_ready  = 1'b1;

   assign start_ext = PHASE_BITS'({{(PHASE_MAX_BITS-STEP_BITS){1'b0}}, start_ff});
   assign chirp_ext = PHASE_BITS'({{(PHASE_MAX_BITS-STEP_BITS){chirp_ff[STEP_BITS-1]}},
                                   chirp_ff});
   assign chirp_two = {chirp_ext[PHASE_BITS-2:0], 1'b0};

   // A restart replaces the state before the sample is taken.
   always_comb begin
      if (restart) begin
         cur_acc   = '0;
         cur_inc   = is_chirp ? start_ext + chirp_ext : start_ext;
         cur_index = '0;
         cur_run   = (count_ff != '0);
      end else begin
         cur_acc   = acc_ff;
         cur_inc   = inc_ff;
         cur_index = index_ff;
         cur_run   = running_ff;
      end
   end

   assign emit = cur_run;
   assign last = ({1'b0, cur_index} + (COUNT_BITS+1)'(1)) >= {1'b0, count_ff};

   always_comb begin
      if (emit) begin
         acc_in     = cur_acc + cur_inc;
         inc_in     = is_chirp ? cur_inc + chirp_two : cur_inc;
         index_in   = cur_index + COUNT_BITS'(1);
         running_in = !last;
      end else begin
         acc_in     = cur_acc;
         inc_in     = cur_inc;
         index_in   = cur_index;
         running_in = cur_run;
      end
   end

   // Quadrants one and three read the table backwards.
   assign quad     = cur_acc[PHASE_BITS-1 -: 2];
   assign tab_idx  = cur_acc[PHASE_BITS-3 -: TAB_LOG2];
   assign rom_addr = quad[0] ? ADDR_BITS'(DEPTH) - {1'b0, tab_idx} : {1'b0, tab_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         start_ff <= '0;
         chirp_ff <= '0;
         count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODE:  mode_ff  <= csr_wdata[MODE_BITS-1:0];
            CSR_START: start_ff <= csr_wdata;
            CSR_CHIRP: chirp_ff <= csr_wdata;
            CSR_COUNT: count_ff <= csr_wdata[COUNT_BITS-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         inc_ff     <= '0;
         index_ff   <= '0;
         running_ff <= 1'b0;
      end else if (accept) begin
         acc_ff     <= acc_in;
         inc_ff     <= inc_in;
         index_ff   <= index_in;
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         rom_q_ff   <= SINE_ROM[rom_addr];
         s1_neg_ff  <= quad[1];
         s1_mute_ff <= (mode_ff != MODE_TONE) && (mode_ff != MODE_CHIRP);
         s1_last_ff <= last;
      end
   end

   always_comb begin
      if (s1_mute_ff) begin
         sample_val = '0;
      end else if (s1_neg_ff) begin
         sample_val = -rom_q_ff;
      end else begin
         sample_val = rom_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv2) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         rsp_data_ff <= RSP_DATA_BITS'($unsigned(sample_val));
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      accept && emit && last |=> !running_ff)
      else $error("run did not end after its last sample");

   a_empty_restart: assert property (@(posedge clock) disable iff (reset)
      accept && restart && (count_ff == '0) |=> !s1_valid_ff && !running_ff)
      else $error("restart with zero count produced a word");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv2 |=> s1_valid_ff && $stable(rom_q_ff) && $stable(s1_last_ff))
      else $error("table read stage lost its word during a stall");

   a_no_min_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[SAMPLE_BITS-1:0] != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
      else $error("sample outside the table amplitude");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff && !running_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
   import tcg_pkg::*;

   localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
   localparam int PHASE_W      = PHASE_BITS_DEF;
   localparam int TABLE_BITS   = 10;
   localparam int TABLE_SIZE   = 1 << TABLE_BITS;
   localparam int RSP_W        = ((SAMPLE_W + 7) / 8) * 8;
   localparam int ITEM_TARGET  = 950;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 60;
   localparam int END_WAIT     = 2000;
   localparam int IDLE_PERCENT = 22;
   localparam longint TIMEOUT  = 64'd4_000_000;

   localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629711;
   localparam longint          UNIT_Q30    = 64'sd1073741824;
   localparam longint          AMPLITUDE   = (64'sd1 <<< (SAMPLE_W - 1)) - 1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] level;
      logic                       last;
   } sample_word_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [REQ_DATA_BITS-1:0]      req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [RSP_W-1:0]              rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index  = '0;
   logic [STEP_BITS-1:0]          csr_wdata  = '0;

   // Oscillator copy: register settings and the running state.
   logic [MODE_BITS-1:0]  cfg_mode  = MODE_TONE;
   logic [STEP_BITS-1:0]  cfg_start = '0;
   logic [STEP_BITS-1:0]  cfg_chirp = '0;
   logic [COUNT_BITS-1:0] cfg_count = '0;
   logic [PHASE_W-1:0]    osc_phase = '0;
   logic [PHASE_W-1:0]    osc_inc   = '0;
   logic [COUNT_BITS-1:0] osc_index = '0;
   logic                  osc_running = 1'b0;

   int              quarter_wave [0:TABLE_SIZE];
   sample_word_type pending_samples [$];
   sample_word_type expected_word;

   int tick_count      = 0;
   int samples_checked = 0;
   int write_count     = 0;
   int setting_count   = 0;
   int stall_cycles    = 0;
   int error_count     = 0;
   bit steady_flow        = 1'b0;
   bit hold_off_requested = 1'b0;

   tone_chirp_generator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Taylor series of sine to the eleventh power in Q30, scaled and rounded.
   function automatic int quarter_sine_level(input int unsigned slot);
      longint unsigned angle;
      longint unsigned angle_sq;
      longint unsigned term;
      longint          series;
      int              k;
      angle    = (HALF_PI_Q30 * longint'(slot)) / TABLE_SIZE;
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      series   = longint'(angle);
      for (k = 1; k <= 5; k++) begin
         term = ((term * angle_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) series = series - longint'(term);
         else series = series + longint'(term);
      end
      if (series < 0) series = 0;
      if (series > UNIT_Q30) series = UNIT_Q30;
      series = (series * AMPLITUDE + (UNIT_Q30 >>> 1)) >>> 30;
      if (series > AMPLITUDE) series = AMPLITUDE;
      return int'(series);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sine_at(input logic [PHASE_W-1:0] phase);
      logic [1:0]          quadrant;
      logic [TABLE_BITS:0] slot;
      int                  level;
      quadrant = phase[PHASE_W-1 -: 2];
      slot     = {1'b0, phase[PHASE_W-3 -: TABLE_BITS]};
      // Odd quadrants run the quarter wave backwards, the lower half is negated.
      if (quadrant[0]) slot = (TABLE_BITS + 1)'(TABLE_SIZE) - slot;
      level = quarter_wave[slot];
      if (quadrant[1]) level = -level;
      return level[SAMPLE_W-1:0];
   endfunction

   task automatic advance_oscillator(input logic restart);
      sample_word_type word;
      if (restart) begin
         osc_phase = '0;
         osc_inc   = cfg_start;
         if (cfg_mode == MODE_CHIRP) osc_inc = osc_inc + cfg_chirp;
         osc_index   = '0;
         osc_running = cfg_count != '0;
      end
      if (osc_running) begin
         word.level = (cfg_mode == MODE_TONE || cfg_mode == MODE_CHIRP) ?
                      sine_at(osc_phase) : '0;
         word.last  = ({1'b0, osc_index} + 1'b1) >= {1'b0, cfg_count};
         pending_samples.push_back(word);
         osc_phase = osc_phase + osc_inc;
         if (cfg_mode == MODE_CHIRP) osc_inc = osc_inc + {cfg_chirp[STEP_BITS-2:0], 1'b0};
         osc_index = osc_index + 1'b1;
         if (word.last) osc_running = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready) stall_cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d arrived with none expected",
                                      $signed(rsp_tdata[SAMPLE_W-1:0])));
         end else begin
            expected_word = pending_samples.pop_front();
            samples_checked++;
            if (rsp_tdata[SAMPLE_W-1:0] !== expected_word.level)
               report_mismatch($sformatf("sample %0d, expected %0d",
                                         $signed(rsp_tdata[SAMPLE_W-1:0]),
                                         expected_word.level));
            if (rsp_tlast !== expected_word.last)
               report_mismatch($sformatf("last flag %b, expected %b",
                                         rsp_tlast, expected_word.last));
         end
      end
   end

   // Receiver: random stalls, or one long hold-off when asked for.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_requested) begin
            hold_off_requested = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Called at a falling edge; leaves tvalid high so that back-to-back words need no gap.
   task automatic send_tick(input logic restart);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(restart);
      do @(posedge clock); while (!req_tready);
      advance_oscillator(restart);
      tick_count++;
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      // A tick that yields no word may still be in the pipeline.
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [STEP_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_MODE:  cfg_mode  = value[MODE_BITS-1:0];
         CSR_START: cfg_start = value;
         CSR_CHIRP: cfg_chirp = value;
         CSR_COUNT: cfg_count = value[COUNT_BITS-1:0];
         default: ;
      endcase
      write_count++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [MODE_BITS-1:0] mode, input logic [STEP_BITS-1:0] start,
                            input logic [STEP_BITS-1:0] chirp,
                            input logic [COUNT_BITS-1:0] count);
      drain_block();
      write_register(CSR_MODE, STEP_BITS'(mode));
      write_register(CSR_START, start);
      write_register(CSR_CHIRP, chirp);
      write_register(CSR_COUNT, STEP_BITS'(count));
      setting_count++;
   endtask

   function automatic logic [STEP_BITS-1:0] random_wide();
      return STEP_BITS'({$urandom, $urandom});
   endfunction

   function automatic logic [MODE_BITS-1:0] pick_mode();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return MODE_TONE;
      if (roll < 80) return MODE_CHIRP;
      if (roll < 92) return MODE_SILENCE;
      return MODE_SPARE;
   endfunction

   function automatic logic [STEP_BITS-1:0] pick_start();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2, 3: return random_wide();
         default: return random_wide() >> $urandom_range(47, 16);
      endcase
   endfunction

   function automatic logic [STEP_BITS-1:0] pick_chirp();
      logic signed [STEP_BITS-1:0] value;
      value = random_wide();
      case ($urandom_range(5))
         0: return '0;
         1: return {1'b1, {(STEP_BITS-1){1'b0}}};
         2: return {1'b0, {(STEP_BITS-1){1'b1}}};
         3: return value;
         default: return value >>> $urandom_range(47, 20);
      endcase
   endfunction

   function automatic logic [COUNT_BITS-1:0] pick_count();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 10) return $urandom_range(1) ? '1 : COUNT_BITS'($urandom);
      return COUNT_BITS'($urandom_range(24, 1));
   endfunction

   task automatic test_idle_after_reset();
      // Idle tick, then a restart with the cleared count: neither gives a word.
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   task automatic test_tone_extremes();
      // A quarter turn per sample visits every quadrant and both table ends.
      configure(MODE_TONE, 48'h4000_0000_0000, '0, 24'd5);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      configure(MODE_TONE, '1, '0, 24'd2);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
   endtask

   task automatic test_chirp_extremes();
      configure(MODE_CHIRP, '0, 48'h8000_0000_0000, 24'd3);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      configure(MODE_CHIRP, 48'h1357_9BDF_2468, 48'h7FFF_FFFF_FFFF, 24'd2);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   task automatic test_silence_modes();
      configure(MODE_SILENCE, random_wide(), random_wide(), 24'd2);
      send_tick(1'b1);
      send_tick(1'b0);
      // The spare mode code behaves as silence; the longest count never ends here.
      configure(MODE_SPARE, random_wide(), random_wide(), '1);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   task automatic test_mid_run_writes();
      configure(MODE_TONE, 48'h0123_4567_89AB, 48'h0000_0100_0000, 24'd10);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      // Lowering the count below the position ends the run on the next word.
      drain_block();
      write_register(CSR_COUNT, STEP_BITS'(24'd2));
      send_tick(1'b0);
      send_tick(1'b0);
      drain_block();
      write_register(CSR_COUNT, STEP_BITS'(24'd20));
      send_tick(1'b1);
      drain_block();
      write_register(CSR_MODE, STEP_BITS'(MODE_CHIRP));
      send_tick(1'b0);
      drain_block();
      write_register(CSR_CHIRP, 48'hFFFF_F000_0000);
      send_tick(1'b0);
      drain_block();
      // The start step only counts from the next restart.
      write_register(CSR_START, 48'h0800_0000_0001);
      send_tick(1'b0);
      send_tick(1'b1);
      drain_block();
      write_register(CSR_INDEX_BITS'($urandom_range(255, int'(CSR_COUNT) + 1)), random_wide());
      send_tick(1'b0);
   endtask

   task automatic test_backpressure();
      int n;
      configure(MODE_CHIRP, pick_start(), pick_chirp(), 24'd40);
      steady_flow = 1'b1;
      hold_off_requested = 1'b1;
      send_tick(1'b1);
      for (n = 0; n < 30; n++) send_tick(1'b0);
      drain_block();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_runs();
      logic [COUNT_BITS-1:0] count;
      int                    ticks;
      int                    n;
      while (tick_count < ITEM_TARGET) begin
         steady_flow = tick_count >= 400 && tick_count < 560;
         count = pick_count();
         configure(pick_mode(), pick_start(), pick_chirp(), count);
         if ($urandom_range(9) == 0)
            write_register(CSR_INDEX_BITS'($urandom_range(255, int'(CSR_COUNT) + 1)),
                           random_wide());
         if (count == '0) ticks = 3;
         else if (count > 64) ticks = $urandom_range(40, 4);
         else ticks = int'(count) - 1 + $urandom_range(2);
         send_tick(1'b1);
         for (n = 0; n < ticks; n++) begin
            if (n == ticks / 2 && $urandom_range(9) == 0) begin
               drain_block();
               write_register(CSR_COUNT, STEP_BITS'($urandom_range(8, 1)));
            end
            // Now and then a restart cuts the run short.
            send_tick($urandom_range(19) == 0);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      int slot;
      int waited;
      for (slot = 0; slot <= TABLE_SIZE; slot++) quarter_wave[slot] = quarter_sine_level(slot);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_idle_after_reset();
      test_tone_extremes();
      test_chirp_extremes();
      test_silence_modes();
      test_mid_run_writes();
      test_backpressure();
      test_random_runs();

      req_tvalid <= 1'b0;
      for (waited = 0; pending_samples.size() != 0 && waited < END_WAIT; waited++)
         @(posedge clock);
      if (pending_samples.size() != 0)
         report_mismatch($sformatf("%0d samples never arrived", pending_samples.size()));
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d ticks and checked %0d samples over %0d register settings (%0d writes).",
               tick_count, samples_checked, setting_count, write_count);
      $display("Input held back for %0d cycles; %0d mismatches.", stall_cycles, error_count);
      if (error_count == 0) begin
         $display("** tone_chirp_generator_unit: PASSED **");
      end else begin
         $display("** tone_chirp_generator_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT);
      $display("Run timed out.");
      $display("** tone_chirp_generator_unit: FAILED **");
      $finish;
   end

endmodule

### files.f
rtl/tcg_pkg.sv
rtl/tone_chirp_generator_unit.sv
tb/tb_top.sv
